// File: rtl/adae_pkg.sv
// ----------------------------------------------------------------------------
// adae_pkg: shared types and constants of the apogee estimator
// Divider widths, the divider request and response structs and fixed
// constants used by the core and its serial divider.
// ----------------------------------------------------------------------------
package adae_pkg;

    // serial divider geometry
    localparam int DIV_N_W   = 48;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // window length register
    localparam logic [7:0] WIN_LEN_RESET = 8'd8;
    localparam logic [7:0] WIN_LEN_MIN   = 8'd2;

    // rate saturation limits, signed q16.16, and the time to apogee limit
    localparam logic [31:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] RATE_MIN = 32'h8000_0000;
    localparam logic [31:0] TTA_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                 start;
        logic [DIV_N_W-1:0]   dividend;
        logic [DIV_D_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_N_W-1:0]   quotient;
    } t_div_rsp;

endpackage

// File: rtl/adae_in_if.sv
// ----------------------------------------------------------------------------
// adae_in_if: altitude sample channel
// Valid/ready channel carrying one timestamped altitude sample.
// ----------------------------------------------------------------------------
interface adae_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] altitude_cm;
    logic        [31:0] timestamp_ms;

    modport source (output valid, output altitude_cm, output timestamp_ms, input ready);
    modport sink   (input valid, input altitude_cm, input timestamp_ms, output ready);
endinterface

// File: rtl/adae_out_if.sv
// ----------------------------------------------------------------------------
// adae_out_if: window result channel
// Valid/ready channel carrying one window evaluation result.
// ----------------------------------------------------------------------------
interface adae_out_if;
    logic        valid;
    logic        ready;
    logic        decelerating;
    logic        estimate_valid;
    logic [31:0] apogee_eta;
    logic        timing_fault;

    modport source (output valid, output decelerating, output estimate_valid,
                    output apogee_eta, output timing_fault, input ready);
    modport sink   (input valid, input decelerating, input estimate_valid,
                    input apogee_eta, input timing_fault, output ready);
endinterface

// File: rtl/adae_divider.sv
// ----------------------------------------------------------------------------
// adae_divider: restoring serial divider
// Unsigned 48 by 32 bit division, one quotient bit per cycle. A start
// request loads the operands; done pulses once the quotient is complete.
// ----------------------------------------------------------------------------
module adae_divider
    import adae_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_divisor;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_N_W-1:0]   r_quo;

    logic [DIV_D_W:0]     n_rem_sh;
    logic [DIV_D_W:0]     n_rem_sub;
    logic                 n_bit;

    // one trial subtraction per cycle
    always_comb begin
        n_rem_sh  = {r_rem, r_quo[DIV_N_W-1]};
        n_rem_sub = n_rem_sh - {1'b0, r_divisor};
        n_bit     = (n_rem_sh >= {1'b0, r_divisor});
    end

    // sequencing and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= '0;
                r_divisor <= i_req.divisor;
                r_rem     <= '0;
                r_quo     <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= n_bit ? n_rem_sub[DIV_D_W-1:0] : n_rem_sh[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], n_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/altitude_deceleration_apogee_estimator_core.sv
// ----------------------------------------------------------------------------
// altitude_deceleration_apogee_estimator_core: climb rate and apogee estimator
// Windows timestamped altitude samples, tracks climb-rate deceleration and
// time steps, and reports deceleration, fault and time to apogee per window.
// ----------------------------------------------------------------------------
// flow: a request with a rate waits in S_RATE for the divider; a window's last
// request then passes S_UPDATE, S_EST when the apogee estimate is divided, and
// S_EMIT into the output register. No new request is taken until the last one
// is through; the one serial divider serves rate and estimate alike
// reset: synchronous active low; window length returns to 8, window state clears
// ----------------------------------------------------------------------------
module altitude_deceleration_apogee_estimator_core
    import adae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    adae_in_if.sink     i_sample,
    adae_out_if.source  o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_UPDATE,
        S_EST,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [7:0]         r_win_len;

    // window state
    logic signed [23:0] r_prev_alt;
    logic [31:0]        r_prev_ts;
    logic [31:0]        r_last_rate;
    logic               r_rate_present;
    logic [7:0]         r_count;
    logic               r_trend;
    logic               r_fault;

    // per-request working registers
    logic signed [23:0] r_alt;
    logic [31:0]        r_ts;
    logic               r_neg;
    logic               r_have_pair;
    logic [31:0]        r_prior_rate;

    // pending result and output register
    logic               r_res_decel;
    logic               r_res_valid;
    logic               r_res_fault;
    logic [31:0]        r_res_tta;
    logic               r_out_valid;
    logic               r_out_decel;
    logic               r_out_est_valid;
    logic [31:0]        r_out_tta;
    logic               r_out_fault;

    t_div_req           r_div_req;
    t_div_rsp           w_div_rsp;

    logic               w_accept;
    logic [24:0]        n_diff;
    logic [24:0]        n_mag;
    logic [31:0]        n_rate;
    logic [7:0]         n_count;
    logic [7:0]         n_eff_len;
    logic [32:0]        n_drop;
    logic               n_drop_pos;
    logic               n_last_pos;
    logic [31:0]        n_tta;

    adae_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_sample.ready = (r_state == S_IDLE);
    assign w_accept       = i_sample.valid && i_sample.ready;

    // altitude difference magnitude for the rate division
    always_comb begin
        n_diff = {i_sample.altitude_cm[23], i_sample.altitude_cm}
               - {r_prev_alt[23], r_prev_alt};
        n_mag  = n_diff[24] ? (25'd0 - n_diff) : n_diff;
    end

    // saturate and sign the rate quotient
    always_comb begin
        if (!r_neg) begin
            n_rate = (w_div_rsp.quotient[DIV_N_W-1:31] != '0) ? RATE_MAX
                   : w_div_rsp.quotient[31:0];
        end else begin
            n_rate = (w_div_rsp.quotient > DIV_N_W'(RATE_MIN)) ? RATE_MIN
                   : (32'd0 - w_div_rsp.quotient[31:0]);
        end
    end

    // window end test and estimate operands
    always_comb begin
        n_count    = r_count + 8'd1;
        n_eff_len  = (r_win_len < WIN_LEN_MIN) ? WIN_LEN_MIN : r_win_len;
        n_drop     = {r_prior_rate[31], r_prior_rate} - {r_last_rate[31], r_last_rate};
        n_drop_pos = !n_drop[32] && (n_drop != '0);
        n_last_pos = !r_last_rate[31] && (r_last_rate != '0);
        n_tta      = (w_div_rsp.quotient[DIV_N_W-1:32] != '0) ? TTA_MAX
                   : w_div_rsp.quotient[31:0];
    end

    // sequencer, window state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_win_len       <= WIN_LEN_RESET;
            r_prev_alt      <= '0;
            r_prev_ts       <= '0;
            r_last_rate     <= '0;
            r_rate_present  <= 1'b0;
            r_count         <= '0;
            r_trend         <= 1'b1;
            r_fault         <= 1'b0;
            r_have_pair     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (i_cfg_we) begin
                r_win_len <= i_cfg_wdata;
            end
            if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_alt       <= i_sample.altitude_cm;
                        r_ts        <= i_sample.timestamp_ms;
                        r_have_pair <= 1'b0;
                        if (r_count == '0) begin
                            r_state <= S_UPDATE;
                        end else if (i_sample.timestamp_ms <= r_prev_ts) begin
                            r_fault        <= 1'b1;
                            r_rate_present <= 1'b0;
                            r_state        <= S_UPDATE;
                        end else begin
                            r_neg              <= n_diff[24];
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= {7'd0, n_mag, 16'd0};
                            r_div_req.divisor  <= i_sample.timestamp_ms - r_prev_ts;
                            r_state            <= S_RATE;
                        end
                    end
                end

                S_RATE: begin
                    if (w_div_rsp.done) begin
                        if (r_rate_present) begin
                            if ($signed(n_rate) > $signed(r_last_rate)) begin
                                r_trend <= 1'b0;
                            end
                            r_prior_rate <= r_last_rate;
                            r_have_pair  <= 1'b1;
                        end
                        r_last_rate    <= n_rate;
                        r_rate_present <= 1'b1;
                        r_state        <= S_UPDATE;
                    end
                end

                S_UPDATE: begin
                    if (n_count < n_eff_len) begin
                        r_prev_alt <= r_alt;
                        r_prev_ts  <= r_ts;
                        r_count    <= n_count;
                        r_state    <= S_IDLE;
                    end else begin
                        r_res_decel <= r_trend;
                        r_res_fault <= r_fault;
                        r_res_tta   <= '0;
                        r_res_valid <= r_trend && !r_fault && r_have_pair && n_drop_pos;
                        if (r_trend && !r_fault && r_have_pair && n_drop_pos && n_last_pos) begin
                            r_div_req.start    <= 1'b1;
                            r_div_req.dividend <= {r_last_rate, 16'd0};
                            r_div_req.divisor  <= n_drop[31:0];
                            r_state            <= S_EST;
                        end else begin
                            r_state <= S_EMIT;
                        end
                        // fresh window
                        r_prev_alt     <= '0;
                        r_prev_ts      <= '0;
                        r_last_rate    <= '0;
                        r_rate_present <= 1'b0;
                        r_count        <= '0;
                        r_trend        <= 1'b1;
                        r_fault        <= 1'b0;
                    end
                end

                S_EST: begin
                    if (w_div_rsp.done) begin
                        r_res_tta <= n_tta;
                        r_state   <= S_EMIT;
                    end
                end

                S_EMIT: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid     <= 1'b1;
                        r_out_decel     <= r_res_decel;
                        r_out_est_valid <= r_res_valid;
                        r_out_tta       <= r_res_tta;
                        r_out_fault     <= r_res_fault;
                        r_state         <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.decelerating   = r_out_decel;
    assign o_result.estimate_valid = r_out_est_valid;
    assign o_result.apogee_eta     = r_out_tta;
    assign o_result.timing_fault   = r_out_fault;

`ifndef SYNTHESIS
    // divider start only leads into a divider wait state
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_req.start |-> (r_state == S_RATE || r_state == S_EST))
        else $error("divider started outside a wait state");

    // no new request is taken while a division is being launched
    a_ready_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.ready |-> !r_div_req.start)
        else $error("ready during divider start");

    // a valid estimate implies deceleration and no fault
    a_est_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.estimate_valid)
            |-> (o_result.decelerating && !o_result.timing_fault))
        else $error("estimate valid with inconsistent flags");

    // an invalid estimate reports zero time to apogee
    a_tta_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.estimate_valid) |-> (o_result.apogee_eta == '0))
        else $error("nonzero time to apogee without valid estimate");

    // a pending result waits while the output register is blocked
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !o_result.ready) |=> (r_state == S_EMIT))
        else $error("result dropped while output stalled");
`endif

endmodule
